// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PFLA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PFLA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: sv/pfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_pkg
// Types and constants of the paged free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

	localparam int MAX_SLOTS        = 1024;
	localparam int PAGE_LIMIT       = 16;
	localparam int PAGE_OBJECTS_MAX = 64;
	localparam int INIT_PAGE_CAP     = 3;
	localparam int DEFAULT_OPP       = 4;

	localparam int SLOT_W = 10;
	localparam int CNT_W  = 11;
	localparam int OPP_W  = 7;
	localparam int PAGE_W = 5;
	localparam int TOT_W  = 32;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 104;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_PAGES = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_OBJECTS_PER_PAGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES        = 1'd1;

	typedef struct packed {
		logic              commit;
		logic              func;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [SLOT_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic [TOT_W-1:0]  total_frees;
		logic [TOT_W-1:0]  total_allocations;
		logic [PAGE_W-1:0] pages_in_use;
		logic [CNT_W-1:0]  free_objects;
		logic [CNT_W-1:0]  objects_in_use;
		logic              status;
		logic [SLOT_W-1:0] granted_slot;
	} result_t;

endpackage

// File: sv/pfla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/pfla_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pfla_core
// Allocator state registers and the next-state / result logic.
// ----------------------------------------------------------------------------
module pfla_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pfla_pkg::cmd_t               cmd,
	input  logic [pfla_pkg::OPP_W-1:0]   opp_cfg,
	input  logic [pfla_pkg::PAGE_W-1:0]  max_pages_cfg,
	input  logic [pfla_pkg::SLOT_W-1:0]  link_rdata,
	output logic [pfla_pkg::SLOT_W-1:0]  head,
	output logic                         list_nonempty,
	output pfla_pkg::link_wr_t           link_wr,
	output pfla_pkg::result_t            res
);

	logic [pfla_pkg::SLOT_W-1:0] head_q, head_n;
	logic [pfla_pkg::CNT_W-1:0]  count_q, count_n;
	logic [pfla_pkg::OPP_W-1:0]  fresh_q, fresh_n;
	logic [pfla_pkg::PAGE_W-1:0] page_q, page_n;
	logic [pfla_pkg::CNT_W-1:0]  in_use_q, in_use_n;
	logic [pfla_pkg::TOT_W-1:0]  alloc_tot_q, alloc_tot_n;
	logic [pfla_pkg::TOT_W-1:0]  free_tot_q, free_tot_n;

	logic [pfla_pkg::OPP_W-1:0]  opp_eff;
	logic [11:0]                 prod_cur;
	logic                        page_fits;
	logic [pfla_pkg::OPP_W-1:0]  remain;
	logic [11:0]                 free_sum;
	logic                        granted_ok;
	logic                        free_commit;

	assign head          = head_q;
	assign list_nonempty = (count_q != '0);
	assign free_commit   = cmd.commit && (cmd.func == pfla_pkg::FUNC_FREE);

	always_comb begin
		if (opp_cfg == '0) begin
			opp_eff = pfla_pkg::OPP_W'(1);
		end else if (opp_cfg > pfla_pkg::OPP_W'(pfla_pkg::PAGE_OBJECTS_MAX)) begin
			opp_eff = pfla_pkg::OPP_W'(pfla_pkg::PAGE_OBJECTS_MAX);
		end else begin
			opp_eff = opp_cfg;
		end
	end

	// Slots of all pages so far, the newest included: page_count * objects_per_page.
	assign prod_cur  = 12'(page_q) * 12'(opp_eff);
	assign page_fits = (13'(prod_cur) + 13'(opp_eff)) <= 13'(pfla_pkg::MAX_SLOTS);

	always_comb begin
		head_n      = head_q;
		count_n     = count_q;
		fresh_n     = fresh_q;
		page_n      = page_q;
		in_use_n    = in_use_q;
		alloc_tot_n = alloc_tot_q;
		free_tot_n  = free_tot_q;
		granted_ok  = 1'b1;
		res         = '0;
		res.status  = pfla_pkg::STATUS_OK;
		link_wr.we   = 1'b0;
		link_wr.addr = cmd.slot;
		link_wr.data = head_q;

		if (cmd.func == pfla_pkg::FUNC_ALLOC) begin
			if (count_q != '0) begin
				res.granted_slot = head_q;
				head_n           = link_rdata;
				count_n          = count_q - 1'b1;
			end else if (fresh_q < opp_eff) begin
				// Newest page hands out slots from the top down.
				res.granted_slot = pfla_pkg::SLOT_W'(prod_cur - 12'd1 - 12'(fresh_q));
				fresh_n          = fresh_q + 1'b1;
			end else if (page_q < max_pages_cfg &&
					page_q < pfla_pkg::PAGE_W'(pfla_pkg::PAGE_LIMIT) && page_fits) begin
				page_n           = page_q + 1'b1;
				res.granted_slot = pfla_pkg::SLOT_W'(prod_cur + 12'(opp_eff) - 12'd1);
				fresh_n          = pfla_pkg::OPP_W'(1);
			end else begin
				granted_ok = 1'b0;
				res.status = pfla_pkg::STATUS_NO_PAGES;
			end
			if (granted_ok) begin
				if (in_use_q != pfla_pkg::CNT_MAX) begin
					in_use_n = in_use_q + 1'b1;
				end
				if (alloc_tot_q != pfla_pkg::TOT_MAX) begin
					alloc_tot_n = alloc_tot_q + 1'b1;
				end
			end
		end else begin
			link_wr.we = cmd.commit;
			head_n     = cmd.slot;
			if (count_q != pfla_pkg::CNT_MAX) begin
				count_n = count_q + 1'b1;
			end
			if (in_use_q != '0) begin
				in_use_n = in_use_q - 1'b1;
			end
			if (free_tot_q != pfla_pkg::TOT_MAX) begin
				free_tot_n = free_tot_q + 1'b1;
			end
		end

		remain   = (fresh_n < opp_eff) ? (opp_eff - fresh_n) : '0;
		free_sum = 12'(count_n) + 12'(remain);

		res.objects_in_use    = in_use_n;
		res.free_objects      = free_sum[11] ? pfla_pkg::CNT_MAX : free_sum[10:0];
		res.pages_in_use      = page_n;
		res.total_allocations = alloc_tot_n;
		res.total_frees       = free_tot_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			page_q      <= pfla_pkg::PAGE_W'(1);
			in_use_q    <= '0;
			alloc_tot_q <= '0;
			free_tot_q  <= '0;
		end else if (cmd.commit) begin
			head_q      <= head_n;
			count_q     <= count_n;
			fresh_q     <= fresh_n;
			page_q      <= page_n;
			in_use_q    <= in_use_n;
			alloc_tot_q <= alloc_tot_n;
			free_tot_q  <= free_tot_n;
		end
	end

	`PFLA_ASSERT(a_free_fills_list, free_commit |=> list_nonempty, "free left the list empty")
	`PFLA_NEVER(a_page_zero, page_q == '0, "page count dropped to zero")
	`PFLA_NEVER(a_fresh_over, fresh_q > pfla_pkg::OPP_W'(pfla_pkg::PAGE_OBJECTS_MAX), "fresh overrun")

endmodule

// File: sv/paged_free_list_allocator.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// paged_free_list_allocator
// Fixed-size object allocator with a LIFO free list kept in a link RAM.
// ----------------------------------------------------------------------------
// A free, or an allocate served from the newest page (or a freshly added
// page), completes at the edge that accepts it; an allocate that pops the free
// list waits in ST_LINK, because the link of the list head comes out of the
// registered read port of the 1024 x 10 link RAM. The result is loaded into an
// output register at the edge that completes the transaction and held there
// until taken. The next transaction is accepted no earlier than the cycle in
// which the waiting result is taken, so a stalled output holds the input off.
// The link RAM has no clearing pass: the block is ready right after reset.
module paged_free_list_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pfla_pkg::IN_DATA_W-1:0]     s_tdata,  // slot[9:0], zero pad
	input  logic [0:0]                         s_tuser,  // func[0]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// granted_slot[9:0], objects_in_use[20:10], free_objects[31:21],
	// pages_in_use[36:32], total_allocations[68:37], total_frees[100:69], zero pad
	output logic [pfla_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [0:0]                         m_tuser,  // status[0]
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfla_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LINK = 1'b1;

	logic                          state_q;
	logic [pfla_pkg::OPP_W-1:0]    opp_q;
	logic [pfla_pkg::PAGE_W-1:0]   max_pages_q;
	logic                          out_valid_q;
	pfla_pkg::result_t             out_q;

	logic                          accept;
	logic                          is_pop;
	pfla_pkg::cmd_t                cmd;
	pfla_pkg::link_wr_t            link_wr;
	pfla_pkg::result_t             res;
	logic [pfla_pkg::SLOT_W-1:0]   head;
	logic [pfla_pkg::SLOT_W-1:0]   link_rdata;
	logic                          list_nonempty;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign is_pop    = accept && (s_tuser[0] == pfla_pkg::FUNC_ALLOC) && list_nonempty;

	always_comb begin
		cmd.commit = (accept && !is_pop) || (state_q == ST_LINK);
		cmd.func   = (state_q == ST_LINK) ? pfla_pkg::FUNC_ALLOC : s_tuser[0];
		cmd.slot   = s_tdata[pfla_pkg::SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opp_q       <= pfla_pkg::OPP_W'(pfla_pkg::DEFAULT_OPP);
			max_pages_q <= pfla_pkg::PAGE_W'(pfla_pkg::INIT_PAGE_CAP);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfla_pkg::CFG_OBJECTS_PER_PAGE: begin
					opp_q <= cfg_data;
				end
				pfla_pkg::CFG_MAX_PAGES: begin
					max_pages_q <= cfg_data[pfla_pkg::PAGE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Hold in ST_LINK while the head link comes back from the link RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (is_pop) begin
						state_q <= ST_LINK;
					end
				end
				ST_LINK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {3'b000, out_q.total_frees, out_q.total_allocations,
		out_q.pages_in_use, out_q.free_objects, out_q.objects_in_use, out_q.granted_slot};

	pfla_ram #(
		.WIDTH(pfla_pkg::SLOT_W),
		.DEPTH(pfla_pkg::MAX_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_wr.we),
		.waddr(link_wr.addr),
		.wdata(link_wr.data),
		.raddr(head),
		.rdata(link_rdata)
	);

	pfla_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opp_cfg      (opp_q),
		.max_pages_cfg(max_pages_q),
		.link_rdata   (link_rdata),
		.head         (head),
		.list_nonempty(list_nonempty),
		.link_wr      (link_wr),
		.res          (res)
	);

	`PFLA_ASSERT(a_link_one_cycle, state_q == ST_LINK |=> state_q == ST_IDLE, "link wait too long")
	`PFLA_ASSERT(a_pop_waits, is_pop |=> state_q == ST_LINK && !s_tready, "pop did not wait")
	`PFLA_NEVER(a_out_overwrite, cmd.commit && out_valid_q && !m_tready, "result overwritten")
	`PFLA_NEVER(a_pop_with_write, state_q == ST_LINK && link_wr.we, "link write during pop")

endmodule

// File: verif/alloc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_result_checker
// Tracks the allocator's free list, page growth and totals from the accepted
// input and configuration transactions. Compares every result transaction
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module alloc_result_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [pfla_pkg::IN_DATA_W-1:0]     s_tdata,  // slot[9:0], zero pad
	input  logic [0:0]                         s_tuser,  // func[0]
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// granted_slot[9:0], objects_in_use[20:10], free_objects[31:21],
	// pages_in_use[36:32], total_allocations[68:37], total_frees[100:69], zero pad
	input  logic [pfla_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic [0:0]                         m_tuser,  // status[0]
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfla_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                 errors,
	output int                                 owed
);
	import pfla_pkg::*;

	// Same bit order as m_tdata, lowest field last.
	typedef struct packed {
		logic [TOT_W-1:0]  frees;
		logic [TOT_W-1:0]  allocs;
		logic [PAGE_W-1:0] pages;
		logic [CNT_W-1:0]  free_objs;
		logic [CNT_W-1:0]  in_use;
		logic [SLOT_W-1:0] granted;
	} tally_t;

	typedef struct packed {
		logic   status;
		tally_t t;
	} outcome_t;

	logic [OPP_W-1:0]  opp_reg;
	logic [PAGE_W-1:0] maxp_reg;

	logic [SLOT_W-1:0] next_link [MAX_SLOTS];
	logic [SLOT_W-1:0] freed_head;
	logic [CNT_W-1:0]  freed_count;
	logic [OPP_W-1:0]  fresh_taken;
	logic [PAGE_W-1:0] page_count;
	logic [CNT_W-1:0]  in_use_count;
	logic [TOT_W-1:0]  alloc_total;
	logic [TOT_W-1:0]  free_total;

	outcome_t outstanding [$];
	int       mism;

	// Slots of the newest page are handed out from the top down.
	function automatic logic [SLOT_W-1:0] fresh_slot(input int opp);
		return SLOT_W'((int'(page_count) - 1) * opp + (opp - 1 - int'(fresh_taken)));
	endfunction

	function automatic outcome_t apply_op(input logic op, input logic [SLOT_W-1:0] slot);
		int       opp;
		int       remain;
		int       free_sum;
		logic     ok;
		outcome_t r;
		opp = (opp_reg == 0) ? 1 :
			((opp_reg > PAGE_OBJECTS_MAX) ? PAGE_OBJECTS_MAX : int'(opp_reg));
		r = '0;
		if (op == FUNC_ALLOC) begin
			ok = 1'b1;
			if (freed_count != 0) begin
				r.t.granted = freed_head;
				freed_head  = next_link[freed_head];
				freed_count = freed_count - 1'b1;
			end else if (fresh_taken < opp) begin
				r.t.granted = fresh_slot(opp);
				fresh_taken = fresh_taken + 1'b1;
			end else if (page_count < maxp_reg && page_count < PAGE_LIMIT &&
					(int'(page_count) + 1) * opp <= MAX_SLOTS) begin
				page_count  = page_count + 1'b1;
				fresh_taken = '0;
				r.t.granted = fresh_slot(opp);
				fresh_taken = OPP_W'(1);
			end else begin
				ok       = 1'b0;
				r.status = STATUS_NO_PAGES;
			end
			if (ok) begin
				if (in_use_count != CNT_MAX) in_use_count = in_use_count + 1'b1;
				if (alloc_total != TOT_MAX) alloc_total = alloc_total + 1'b1;
			end
		end else begin
			next_link[slot] = freed_head;
			freed_head      = slot;
			if (freed_count != CNT_MAX) freed_count = freed_count + 1'b1;
			if (in_use_count != 0) in_use_count = in_use_count - 1'b1;
			if (free_total != TOT_MAX) free_total = free_total + 1'b1;
		end
		remain   = (fresh_taken < opp) ? opp - int'(fresh_taken) : 0;
		free_sum = int'(freed_count) + remain;
		if (free_sum > int'(CNT_MAX)) free_sum = int'(CNT_MAX);
		r.t.in_use    = in_use_count;
		r.t.free_objs = CNT_W'(free_sum);
		r.t.pages     = page_count;
		r.t.allocs    = alloc_total;
		r.t.frees     = free_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [TOT_W-1:0] want,
			input logic [TOT_W-1:0] got);
		if (want !== got) begin
			mism++;
			if (mism <= 10)
				$display("mismatch in %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			opp_reg      = OPP_W'(DEFAULT_OPP);
			maxp_reg     = PAGE_W'(INIT_PAGE_CAP);
			for (int i = 0; i < MAX_SLOTS; i++) next_link[i] = '0;
			freed_head   = '0;
			freed_count  = '0;
			fresh_taken  = '0;
			page_count   = PAGE_W'(1);
			in_use_count = '0;
			alloc_total  = '0;
			free_total   = '0;
			mism         = 0;
			outstanding.delete();
			errors <= 0;
			owed   <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (outstanding.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("result with nothing outstanding: tdata %h", m_tdata);
				end else begin
					want     = outstanding.pop_front();
					got.t    = tally_t'(m_tdata[$bits(tally_t)-1:0]);
					got.status = m_tuser[0];
					check_field("granted_slot", want.t.granted, got.t.granted);
					check_field("status", want.status, got.status);
					check_field("objects_in_use", want.t.in_use, got.t.in_use);
					check_field("free_objects", want.t.free_objs, got.t.free_objs);
					check_field("pages_in_use", want.t.pages, got.t.pages);
					check_field("total_allocations", want.t.allocs, got.t.allocs);
					check_field("total_frees", want.t.frees, got.t.frees);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_OBJECTS_PER_PAGE) opp_reg = cfg_data;
				else maxp_reg = cfg_data[PAGE_W-1:0];
			end
			if (s_tvalid && s_tready)
				outstanding.push_back(apply_op(s_tuser[0], s_tdata[SLOT_W-1:0]));
			errors <= mism;
			owed   <= outstanding.size();
		end
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate and free transactions into the paged free-list allocator:
// a directed opening at the reset configuration, then random phases over a
// series of page sizes and page limits, with bursty input and a stalling
// result side. The checker beside the block reports mismatches.
// ----------------------------------------------------------------------------
module tb_top;
	import pfla_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		int opp;
		int maxp;
		int n_ops;
		int alloc_pct;
	} phase_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;
	logic [0:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int errors;
	int owed;

	logic              op_fifo [$];
	logic [SLOT_W-1:0] live_slots [$];

	int rx_mode;
	int seg_left;
	int stall_left;

	always #5 clk = ~clk;

	paged_free_list_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	alloc_result_checker u_results (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.owed     (owed)
	);

	// Receiver: segments of always-ready, random ready, and long stalls.
	always @(posedge clk) begin : rx_pattern
		if (seg_left == 0) begin
			rx_mode  = $urandom_range(0, 2);
			seg_left = $urandom_range(20, 150);
		end
		seg_left--;
		case (rx_mode)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (stall_left != 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
					stall_left = $urandom_range(1, 8);
				end
			end
		endcase
	end

	// Keep a pool of granted slots so most frees return live objects.
	always @(posedge clk) begin : slot_pool
		logic op;
		if (m_tvalid && m_tready && op_fifo.size() != 0) begin
			op = op_fifo.pop_front();
			if (op == FUNC_ALLOC && m_tuser[0] == STATUS_OK)
				live_slots.push_back(m_tdata[SLOT_W-1:0]);
		end
		if (s_tvalid && s_tready) op_fifo.push_back(s_tuser[0]);
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_op(input logic op, input logic [SLOT_W-1:0] slot);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_DATA_W'(slot);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		do @(posedge clk); while (owed != 0);
	endtask

	task automatic write_cfg(input logic [OPP_W-1:0] opp, input logic [PAGE_W-1:0] pages);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_OBJECTS_PER_PAGE;
		cfg_data  <= opp;
		do @(posedge clk); while (!cfg_ready);
		// upper data bits are don't-care for the page limit; toggle them anyway
		cfg_index <= CFG_MAX_PAGES;
		cfg_data  <= CFG_DATA_W'({$urandom_range(0, 3), pages});
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_op(input int alloc_pct);
		int                idx;
		logic [SLOT_W-1:0] slot;
		if ($urandom_range(0, 99) < alloc_pct) begin
			send_op(FUNC_ALLOC, SLOT_W'($urandom));
		end else if (live_slots.size() != 0 && $urandom_range(0, 99) < 85) begin
			idx  = $urandom_range(0, live_slots.size() - 1);
			slot = live_slots[idx];
			live_slots.delete(idx);
			send_op(FUNC_FREE, slot);
		end else begin
			send_op(FUNC_FREE, SLOT_W'($urandom));
		end
	endtask

	task automatic run_phase(input int n_ops, input int alloc_pct);
		int done;
		int burst;
		int gap;
		done = 0;
		while (done < n_ops) begin
			burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
			for (int k = 0; k < burst && done < n_ops; k++) begin
				send_random_op(alloc_pct);
				done++;
			end
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 29) == 0) begin
				s_tvalid <= 1'b0;
				drain();
			end else if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin : stimulus
		phase_t plan [8];
		int     opp;
		int     maxp;
		plan = '{
			'{0, 0, 120, 50},
			'{1, 5, 120, 60},
			'{2, 1, 100, 30},
			'{127, 31, 280, 70},
			'{64, 16, 200, 50},
			'{-1, -1, 150, 50},
			'{-1, -1, 150, 50},
			'{3, 2, 100, 45}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: three pages of four, then out of pages.
		repeat (13) send_op(FUNC_ALLOC, '0);
		send_op(FUNC_FREE, SLOT_W'(1023));
		send_op(FUNC_FREE, SLOT_W'(0));
		send_op(FUNC_FREE, SLOT_W'(5));
		// LIFO pops, then out of pages again
		repeat (4) send_op(FUNC_ALLOC, SLOT_W'(1023));
		send_op(FUNC_FREE, SLOT_W'(682));
		send_op(FUNC_FREE, SLOT_W'(341));
		// double free of the same slot
		send_op(FUNC_FREE, SLOT_W'(5));
		send_op(FUNC_FREE, SLOT_W'(5));
		s_tvalid <= 1'b0;

		foreach (plan[i]) begin
			drain();
			opp  = (plan[i].opp < 0) ? $urandom_range(0, 127) : plan[i].opp;
			maxp = (plan[i].maxp < 0) ? $urandom_range(0, 31) : plan[i].maxp;
			write_cfg(OPP_W'(opp), PAGE_W'(maxp));
			run_phase(plan[i].n_ops, plan[i].alloc_pct);
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && owed == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
